// ----- design/gbfp_pkg.sv -----
// shared types and constants for the gps binary frame parser
package gbfp_pkg;

  // default upper bound on streamed payload bytes
  localparam int MaxPayloadDef = 256;

  // frame delimiters
  localparam logic [7:0] Sync1   = 8'hA0;
  localparam logic [7:0] Sync2   = 8'hA1;
  localparam logic [7:0] TailCr  = 8'h0D;
  localparam logic [7:0] TailLf  = 8'h0A;

  // per-byte status codes
  typedef enum logic [2:0] {
    ST_MORE       = 3'd0,
    ST_OK         = 3'd1,
    ST_CLIPPED    = 3'd2,
    ST_BADCS      = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_id;
    logic        payload_valid;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [15:0] payload_count;
  } result_t;

endpackage

// ----- design/gps_binary_frame_parser_top.sv -----
// gps binary frame parser: byte-wise frame decode with a two-entry result buffer
//
//  channel   dir   ports                                    transfer when
//  -------   ---   -----------------------------------      -------------------
//  in        in    in_valid, in_ready, in_rx_byte           in_valid & in_ready
//  out       out   out_valid, out_ready, out_status,        out_valid & out_ready
//                  out_frame_id, out_payload_valid,
//                  out_payload_index, out_payload_byte,
//                  out_payload_count
//
// one byte per cycle while in_ready is high: the parse state updates at the input
// transfer and the result is registered into the output register, or into the
// skid register when the output entry is held
// a skid register holds one result while out_ready is low, so in_ready drops
// only once both result entries are full
// rst_n is synchronous, active low; it returns the parser to sync hunting
module gps_binary_frame_parser_top #(
  parameter int MAX_PAYLOAD = gbfp_pkg::MaxPayloadDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gbfp_pkg::status_t     out_status,
  output logic [7:0]            out_frame_id,
  output logic                  out_payload_valid,
  output logic [7:0]            out_payload_index,
  output logic [7:0]            out_payload_byte,
  output logic [15:0]           out_payload_count
);

  // payload limit widened so that 65535 still compares correctly
  localparam logic [16:0] MaxPl = 17'(MAX_PAYLOAD);

  // one-hot parse phases
  typedef enum logic [8:0] {
    PH_HUNT   = 9'b000000001,
    PH_SYNC2  = 9'b000000010,
    PH_LEN_HI = 9'b000000100,
    PH_LEN_LO = 9'b000001000,
    PH_ID     = 9'b000010000,
    PH_PAY    = 9'b000100000,
    PH_CSUM   = 9'b001000000,
    PH_CR     = 9'b010000000,
    PH_LF     = 9'b100000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  id_r, id_nxt;

  gbfp_pkg::result_t res_nxt;
  gbfp_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;

  logic in_fire, out_fire;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  // next parse state and the result for the byte at the input
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    id_nxt    = id_r;
    res_nxt.status        = gbfp_pkg::ST_MORE;
    res_nxt.payload_valid = 1'b0;
    res_nxt.payload_index = 8'd0;
    res_nxt.payload_byte  = 8'd0;
    unique case (phase_r)
      PH_HUNT: begin
        if (in_rx_byte == gbfp_pkg::Sync1) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        // a wrong second sync byte is not retried as a first one
        phase_nxt = (in_rx_byte == gbfp_pkg::Sync2) ? PH_LEN_HI : PH_HUNT;
      end
      PH_LEN_HI: begin
        rem_nxt   = {in_rx_byte, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        rem_nxt   = {rem_r[15:8], in_rx_byte};
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt  = in_rx_byte;
        xor_nxt = in_rx_byte;
        cnt_nxt = 16'd0;
        // length of zero or one means no payload
        if (rem_r > 16'd1) begin
          rem_nxt   = rem_r - 16'd1;
          phase_nxt = PH_PAY;
        end else begin
          rem_nxt   = 16'd0;
          phase_nxt = PH_CSUM;
        end
      end
      PH_PAY: begin
        if ({1'b0, cnt_r} < MaxPl) begin
          res_nxt.payload_valid = 1'b1;
          res_nxt.payload_index = cnt_r[7:0];
          res_nxt.payload_byte  = in_rx_byte;
        end
        // count saturates at all ones
        if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
        xor_nxt = xor_r ^ in_rx_byte;
        if (cnt_nxt >= rem_r) phase_nxt = PH_CSUM;
      end
      PH_CSUM: begin
        if (in_rx_byte == xor_r) begin
          phase_nxt = PH_CR;
        end else begin
          phase_nxt      = PH_HUNT;
          res_nxt.status = gbfp_pkg::ST_BADCS;
        end
      end
      PH_CR: begin
        // anything but carriage return is skipped
        if (in_rx_byte == gbfp_pkg::TailCr) phase_nxt = PH_LF;
      end
      PH_LF: begin
        phase_nxt = PH_HUNT;
        if (in_rx_byte == gbfp_pkg::TailLf) begin
          res_nxt.status = ({1'b0, cnt_r} <= MaxPl) ? gbfp_pkg::ST_OK
                                                    : gbfp_pkg::ST_CLIPPED;
        end else begin
          res_nxt.status = gbfp_pkg::ST_INCOMPLETE;
        end
      end
      default: begin
        phase_nxt      = PH_HUNT;
        res_nxt.status = gbfp_pkg::ST_INCOMPLETE;
      end
    endcase
    res_nxt.frame_id      = id_nxt;
    res_nxt.payload_count = cnt_nxt;
  end

  // parse state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rem_r   <= 16'd0;
      cnt_r   <= 16'd0;
      xor_r   <= 8'd0;
      id_r    <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      id_r    <= id_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_status        = out_r.status;
  assign out_frame_id      = out_r.frame_id;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_index = out_r.payload_index;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_count = out_r.payload_count;

  // skid entry is only filled behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output entry");

  // a held skid entry moves to the output on the output transfer
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not drained");

  // payload bytes only ever come with status more
  a_payload_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.payload_valid) |-> (out_r.status == gbfp_pkg::ST_MORE))
    else $error("payload byte with final status");

  // non-payload results carry zero index and byte
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.payload_valid)
      |-> (out_r.payload_index == 8'd0 && out_r.payload_byte == 8'd0))
    else $error("stale payload fields");

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("result buffer not empty after reset");

endmodule
